@@ rtl/core/gcdws_pkg.sv @@
// ----------------------------------------------------------------------------
// gcdws_pkg
// Types shared by the running-gcd controller, step unit and top level.
// ----------------------------------------------------------------------------
package gcdws_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,  // waiting for an input transfer
    ST_RUN  = 2'd1,  // step unit iterating
    ST_POST = 2'd2   // result ready, output register still occupied
  } gcdws_state_e;

  // Controller strobes to the step unit and the top-level registers
  typedef struct packed {
    logic load;    // load operands into the step unit
    logic step;    // advance the step unit by one iteration
    logic commit;  // fold result into the running gcd (word not last)
    logic post;    // move result to the output register, clear running gcd
  } gcdws_cmd_t;

endpackage

@@ rtl/core/gcdws_unit.sv @@
// ----------------------------------------------------------------------------
// gcdws_unit
// Binary gcd step unit: one shift or one subtract per cycle.
// ----------------------------------------------------------------------------
module gcdws_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gcdws_pkg::gcdws_cmd_t  cmd_i,
  input  logic [WORD_BITS-1:0]   op_a_i,
  input  logic [WORD_BITS-1:0]   op_b_i,
  output logic                   done_o,
  output logic [WORD_BITS-1:0]   result_o
);

  localparam int KW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] b_q, b_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 a_ge_b;
  logic [WORD_BITS-1:0] diff;

  // single shared compare / subtract
  assign a_ge_b = (a_q >= b_q);
  assign diff   = a_ge_b ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = op_a_i;
      b_d = op_b_i;
      k_d = '0;
    end else if (cmd_i.step) begin
      priority if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_ge_b) begin
        a_d = diff;
      end else begin
        b_d = diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  // operand registers carry payload only
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // finished once either operand is zero; gcd(0,0) gives 0
  assign done_o   = (a_q == '0) || (b_q == '0);
  assign result_o = (a_q | b_q) << k_q;

endmodule

@@ rtl/core/gcdws_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcdws_ctrl
// Sequencer: input transfer, iteration, fold or post of the result.
// ----------------------------------------------------------------------------
module gcdws_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   last_q_i,
  input  logic                   unit_done_i,
  input  logic                   out_free_i,
  output logic                   in_ready_o,
  output gcdws_pkg::gcdws_cmd_t  cmd_o
);

  gcdws_pkg::gcdws_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gcdws_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gcdws_pkg::ST_RUN;
      end
      gcdws_pkg::ST_RUN: begin
        if (unit_done_i) begin
          if (!last_q_i || out_free_i) state_d = gcdws_pkg::ST_IDLE;
          else                         state_d = gcdws_pkg::ST_POST;
        end
      end
      gcdws_pkg::ST_POST: begin
        if (out_free_i) state_d = gcdws_pkg::ST_IDLE;
      end
      default: state_d = gcdws_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      gcdws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gcdws_pkg::ST_RUN: begin
        cmd_o.step   = !unit_done_i;
        cmd_o.commit = unit_done_i && !last_q_i;
        cmd_o.post   = unit_done_i && last_q_i && out_free_i;
      end
      gcdws_pkg::ST_POST: begin
        cmd_o.post = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcdws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/gcd_of_word_sequence.sv @@
// ----------------------------------------------------------------------------
// gcd_of_word_sequence
// Running greatest common divisor over a run of words, one result per run.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one word per transfer, value_i,
// with last_i set on the final word of a run. Output channel
// (out_valid_o / out_ready_i): one transfer per run, gcd_result_o holding
// the gcd of every word of that run; a run of zeros gives 0.
// Each word is folded into the running gcd by a binary gcd step unit that
// does one shift or one subtract per cycle, using that single shared
// compare/subtract/shift unit; a word that meets a running gcd of zero
// needs no shift or subtract. in_ready_o is high only while the sequencer
// is idle, so no new word is taken before the unit is through with the last.
// The result sits in an output register; the next run's words are taken
// while it waits. If the receiver stalls and a further last word finishes,
// the sequencer holds that result and stays not ready until the register
// frees. Reset clears the running gcd, the sequencer and out_valid_o.
// ----------------------------------------------------------------------------
module gcd_of_word_sequence #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] gcd_result_o
);

  gcdws_pkg::gcdws_cmd_t cmd;
  logic                  unit_done;
  logic [WORD_BITS-1:0]  unit_result;
  logic                  out_free;

  logic [WORD_BITS-1:0]  running_q, running_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]  out_q, out_d;

  // output register free, or emptied in this very cycle
  assign out_free = !out_valid_q || out_ready_i;

  gcdws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_q_i    (last_q),
    .unit_done_i (unit_done),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  gcdws_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_a_i   (running_q),
    .op_b_i   (value_i),
    .done_o   (unit_done),
    .result_o (unit_result)
  );

  // running gcd: fold on a non-last word, cleared once a run is posted
  always_comb begin
    running_d = running_q;
    if (cmd.commit)    running_d = unit_result;
    else if (cmd.post) running_d = '0;
  end

  // last flag captured with the word
  assign last_d = cmd.load ? last_i : last_q;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd.post) begin
      out_valid_d = 1'b1;
      out_d       = unit_result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign gcd_result_o = out_q;

  // a posted run leaves the accumulator clear for the next one
  a_post_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.post |=> (running_q == '0))
    else $error("running gcd not cleared after post");

  // a pending result is never overwritten
  a_post_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.post |-> (!out_valid_q || out_ready_i))
    else $error("result posted over an untaken one");

  // only non-last words fold into the accumulator
  a_commit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!last_q && !cmd.post))
    else $error("last word folded instead of posted");

  // no new word is loaded while the unit iterates
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!in_ready_o && !cmd.load))
    else $error("load during iteration");

endmodule
